// ===== rtl/vcs_pkg.sv =====
`default_nettype none
package vcs_pkg;

    localparam int VEL_WIDTH = 24;
    localparam int AXES      = 6;
    localparam int LIN_AXES  = 3;

    localparam int TIME_W = 24;
    localparam int LIM_W  = 23;
    localparam int DT_W   = 16;
    localparam int MD_W   = 20;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W  = 24;

    // divider geometry
    localparam int MAG_W  = VEL_WIDTH + 1;
    localparam int QUO_W  = (MAG_W > MD_W) ? MAG_W : MD_W;
    localparam int DIVS_W = TIME_W + 1;
    localparam int DIVD_W = QUO_W + DIVS_W;

    localparam logic [TIME_W-1:0] MIN_TAU_US = TIME_W'(100);

    // accel*dt / 1e6 taken as ((x >> 6) * ceil(2^47 / 15625)) >> 47, exact for x below 2^39
    localparam int MD_NUM_W     = LIM_W + DT_W;
    localparam int MD_PRE_SHIFT = 6;
    localparam int MD_LO_W      = 17;
    localparam int MD_HI_W      = MD_NUM_W - MD_PRE_SHIFT - MD_LO_W;
    localparam int MD_RECIP_W   = 34;
    localparam logic [MD_RECIP_W-1:0] MD_RECIP = 34'd9007199255;
    localparam int MD_SHIFT     = 47;
    localparam int PP_LO_W      = MD_LO_W + MD_RECIP_W;
    localparam int PP_HI_W      = MD_HI_W + MD_RECIP_W;
    localparam int PP_SUM_W     = PP_HI_W + MD_LO_W;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    localparam logic [1:0] SRC_FRESH = 2'd0;
    localparam logic [1:0] SRC_HELD  = 2'd1;
    localparam logic [1:0] SRC_ZERO  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRESH_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LIN_SPEED     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ANG_SPEED     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LIN_ACCEL     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = CFG_IDX_W'(7);

    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [VEL_WIDTH-1:0] target_vx;
        logic signed [VEL_WIDTH-1:0] target_vy;
        logic signed [VEL_WIDTH-1:0] target_vz;
        logic signed [VEL_WIDTH-1:0] target_wx;
        logic signed [VEL_WIDTH-1:0] target_wy;
        logic signed [VEL_WIDTH-1:0] target_wz;
        logic [TIME_W-1:0]           command_age_us;
        logic [DT_W-1:0]             period_us;
    } in_item_t;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] vel_x;
        logic signed [VEL_WIDTH-1:0] vel_y;
        logic signed [VEL_WIDTH-1:0] vel_z;
        logic signed [VEL_WIDTH-1:0] rate_x;
        logic signed [VEL_WIDTH-1:0] rate_y;
        logic signed [VEL_WIDTH-1:0] rate_z;
        logic [1:0]                  target_source;
    } out_item_t;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic [1:0] src;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/vcs_divider.sv =====
`default_nettype none
module vcs_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [vcs_pkg::DIVD_W-1:0] dividend,
    input  wire logic [vcs_pkg::DIVS_W-1:0] divisor,
    output logic                            done,
    output logic [vcs_pkg::QUO_W-1:0]       quotient
);
    import vcs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  shq_reg, shq_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   trial_sub;

    assign trial     = {rem_reg, shq_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};

    // caller guarantees dividend >> QUO_W is below the divisor
    always_comb
    begin
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[DIVD_W-1:QUO_W];
            shq_next  = dividend[QUO_W-1:0];
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial_sub[DIVS_W-1:0];
                shq_next = {shq_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                shq_next = {shq_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shq_reg <= shq_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = shq_reg;

endmodule
`default_nettype wire

// ===== rtl/vcs_lane.sv =====
`default_nettype none
module vcs_lane (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire vcs_pkg::lane_ctrl_t                 ctrl,
    input  wire logic signed [vcs_pkg::VEL_WIDTH-1:0] target_in,
    input  wire logic [vcs_pkg::LIM_W-1:0]           speed_limit,
    input  wire logic [vcs_pkg::DT_W-1:0]            dt,
    input  wire logic [vcs_pkg::DIVS_W-1:0]          den,
    input  wire logic [vcs_pkg::MD_W-1:0]            step_limit,
    input  wire logic [vcs_pkg::LIM_W-1:0]           deadband,
    output logic                                     done,
    output logic signed [vcs_pkg::VEL_WIDTH-1:0]     shaped
);
    import vcs_pkg::*;

    localparam int XW = ((VEL_WIDTH > LIM_W) ? VEL_WIDTH : LIM_W) + 2;
    localparam int RW = QUO_W + 2;
    localparam int AW = (VEL_WIDTH + 1 > LIM_W) ? VEL_WIDTH + 1 : LIM_W;

    logic signed [VEL_WIDTH-1:0] shaped_reg, shaped_next;
    logic signed [VEL_WIDTH-1:0] rem_tgt_reg, rem_tgt_next;
    logic [MAG_W-1:0]            mag_reg;
    logic                        neg_reg;
    logic [DIVD_W-1:0]           prod_reg;
    logic                        st1_reg, st2_reg;

    logic signed [XW-1:0] t_sel, lim_s, t_clamp, cur_x, diff, diff_neg;
    logic [MAG_W-1:0]     mag_next;

    logic                 div_done;
    logic [QUO_W-1:0]     div_q;
    logic [QUO_W-1:0]     md_x, step;
    logic signed [RW-1:0] cur_r, step_s, r_wide;
    logic [VEL_WIDTH-1:0] r_val;
    logic signed [AW-1:0] r_ext;
    logic [AW-1:0]        r_abs;

    always_comb
    begin
        rem_tgt_next = rem_tgt_reg;
        case (ctrl.src)
            SRC_FRESH:
            begin
                t_sel        = XW'(target_in);
                rem_tgt_next = target_in;
            end
            SRC_HELD: t_sel = XW'(rem_tgt_reg);
            default:  t_sel = '0;
        endcase
        lim_s = $signed({{(XW-LIM_W){1'b0}}, speed_limit});
        if (t_sel > lim_s)
        begin
            t_clamp = lim_s;
        end
        else if (t_sel < -lim_s)
        begin
            t_clamp = -lim_s;
        end
        else
        begin
            t_clamp = t_sel;
        end
        cur_x    = XW'(shaped_reg);
        diff     = t_clamp - cur_x;
        diff_neg = -diff;
        mag_next = diff[XW-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    end

    // slew limit only ever trims the filter step, so it is min(q, step_limit)
    always_comb
    begin
        md_x   = QUO_W'(step_limit);
        step   = (div_q > md_x) ? md_x : div_q;
        cur_r  = RW'(shaped_reg);
        step_s = $signed({2'b00, step});
        r_wide = neg_reg ? (cur_r - step_s) : (cur_r + step_s);
        r_val  = r_wide[VEL_WIDTH-1:0];
        r_ext  = AW'($signed(r_val));
        r_abs  = r_ext[AW-1] ? AW'(-r_ext) : AW'(r_ext);
        shaped_next = shaped_reg;
        if (div_done)
        begin
            shaped_next = (r_abs < AW'(deadband)) ? '0 : $signed(r_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaped_reg  <= '0;
            rem_tgt_reg <= '0;
            st1_reg     <= 1'b0;
            st2_reg     <= 1'b0;
        end
        else
        begin
            st1_reg <= ctrl.start;
            st2_reg <= st1_reg;
            if (ctrl.clear)
            begin
                shaped_reg  <= '0;
                rem_tgt_reg <= '0;
            end
            else
            begin
                shaped_reg <= shaped_next;
                if (ctrl.start)
                begin
                    rem_tgt_reg <= rem_tgt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mag_reg <= mag_next;
            neg_reg <= diff[XW-1];
        end
        if (st1_reg)
        begin
            // rounding to nearest: add half the denominator
            prod_reg <= DIVD_W'(mag_reg) * DIVD_W'(dt) + DIVD_W'(den >> 1);
        end
    end

    vcs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (st2_reg),
        .dividend (prod_reg),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign done   = div_done;
    assign shaped = shaped_reg;

endmodule
`default_nettype wire

// ===== rtl/velocity_command_shaper.sv =====
`default_nettype none
// An update item passes through selection, lane set-up (target capture, product, divider
// start), then a 25-step radix-2 divider per axis, before its result is registered.
// One item at a time: a new item is taken only in idle, after the output register takes
// the last result; a start clears the lanes, a stop gives a zeroed result via done.
// Reset (rst_n, asynchronous, active low) restores register defaults and zeroes state.
module velocity_command_shaper (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire vcs_pkg::in_item_t                in_item,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output vcs_pkg::out_item_t                    out_item,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [vcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vcs_pkg::CFG_W-1:0]        cfg_data
);
    import vcs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_M1    = 3'd3;
    localparam logic [2:0] ST_M2    = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [TIME_W-1:0] fresh_reg, hold_reg, tau_reg;
    logic [LIM_W-1:0]  lin_speed_reg, ang_speed_reg, lin_acc_reg, ang_acc_reg, db_reg;

    in_item_t          item_reg;
    logic [1:0]        src_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [DIVS_W-1:0] den_reg;
    logic [MD_NUM_W-1:0] md_num_lin_reg, md_num_ang_reg;
    logic [PP_LO_W-1:0]  pp_lin_lo_reg, pp_ang_lo_reg;
    logic [PP_HI_W-1:0]  pp_lin_hi_reg, pp_ang_hi_reg;
    logic [MD_W-1:0]     md_lin_reg, md_ang_reg;

    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic              in_fire, load_out;
    logic [1:0]        src_next;
    logic [DT_W-1:0]   dt_next;
    logic [TIME_W-1:0] tau_eff;
    logic [TIME_W:0]   hold_edge;

    lane_ctrl_t        lane_ctrl;
    logic signed [VEL_WIDTH-1:0] lane_tgt [AXES];
    logic signed [VEL_WIDTH-1:0] lane_out [AXES];
    logic [AXES-1:0]   lane_done;

    // per-tick slew limit from the two partial products of the reciprocal multiply
    function automatic logic [MD_W-1:0] md_finish(input logic [PP_HI_W-1:0] hi,
                                                  input logic [PP_LO_W-1:0] lo);
        logic [PP_SUM_W-1:0] s;
        s = {hi, MD_LO_W'(0)} + PP_SUM_W'(lo);
        return s[MD_SHIFT +: MD_W];
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        hold_edge = {1'b0, fresh_reg} + {1'b0, hold_reg};
        if (item_reg.command_age_us <= fresh_reg)
        begin
            src_next = SRC_FRESH;
        end
        else if ({1'b0, item_reg.command_age_us} <= hold_edge)
        begin
            src_next = SRC_HELD;
        end
        else
        begin
            src_next = SRC_ZERO;
        end
        dt_next = (item_reg.period_us == '0) ? DT_W'(1) : item_reg.period_us;
        tau_eff = (tau_reg < MIN_TAU_US) ? MIN_TAU_US : tau_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_item.mode == MODE_UPDATE)
                begin
                    state_next = ST_SEL;
                end
                else if (in_fire && in_item.mode == MODE_STOP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SEL:   state_next = ST_START;
            ST_START: state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (&lane_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        lane_ctrl.start = (state_reg == ST_START);
        lane_ctrl.clear = in_fire && (in_item.mode == MODE_START || in_item.mode == MODE_STOP);
        lane_ctrl.src   = src_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fresh_reg     <= TIME_W'(100000);
            hold_reg      <= TIME_W'(200000);
            lin_speed_reg <= LIM_W'(32768);
            ang_speed_reg <= LIM_W'(65536);
            tau_reg       <= TIME_W'(20000);
            lin_acc_reg   <= LIM_W'(65536);
            ang_acc_reg   <= LIM_W'(131072);
            db_reg        <= LIM_W'(66);
            src_reg       <= SRC_FRESH;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire && in_item.mode == MODE_STOP)
            begin
                src_reg <= SRC_ZERO;
            end
            else if (state_reg == ST_SEL)
            begin
                src_reg <= src_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FRESH_TIMEOUT: fresh_reg     <= cfg_data[TIME_W-1:0];
                    REG_HOLD_TIME:     hold_reg      <= cfg_data[TIME_W-1:0];
                    REG_LIN_SPEED:     lin_speed_reg <= cfg_data[LIM_W-1:0];
                    REG_ANG_SPEED:     ang_speed_reg <= cfg_data[LIM_W-1:0];
                    REG_FILTER_TAU:    tau_reg       <= cfg_data[TIME_W-1:0];
                    REG_LIN_ACCEL:     lin_acc_reg   <= cfg_data[LIM_W-1:0];
                    REG_ANG_ACCEL:     ang_acc_reg   <= cfg_data[LIM_W-1:0];
                    REG_DEADBAND:      db_reg        <= cfg_data[LIM_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_item;
        end
        if (state_reg == ST_SEL)
        begin
            dt_reg         <= dt_next;
            den_reg        <= DIVS_W'(tau_eff) + DIVS_W'(dt_next);
            md_num_lin_reg <= MD_NUM_W'(lin_acc_reg) * MD_NUM_W'(dt_next);
            md_num_ang_reg <= MD_NUM_W'(ang_acc_reg) * MD_NUM_W'(dt_next);
        end
        if (state_reg == ST_START)
        begin
            pp_lin_lo_reg <= PP_LO_W'(md_num_lin_reg[MD_PRE_SHIFT +: MD_LO_W])
                             * PP_LO_W'(MD_RECIP);
            pp_lin_hi_reg <= PP_HI_W'(md_num_lin_reg[MD_PRE_SHIFT + MD_LO_W +: MD_HI_W])
                             * PP_HI_W'(MD_RECIP);
            pp_ang_lo_reg <= PP_LO_W'(md_num_ang_reg[MD_PRE_SHIFT +: MD_LO_W])
                             * PP_LO_W'(MD_RECIP);
            pp_ang_hi_reg <= PP_HI_W'(md_num_ang_reg[MD_PRE_SHIFT + MD_LO_W +: MD_HI_W])
                             * PP_HI_W'(MD_RECIP);
        end
        if (state_reg == ST_M1)
        begin
            md_lin_reg <= md_finish(pp_lin_hi_reg, pp_lin_lo_reg);
            md_ang_reg <= md_finish(pp_ang_hi_reg, pp_ang_lo_reg);
        end
        if (load_out)
        begin
            out_item_reg.vel_x         <= lane_out[0];
            out_item_reg.vel_y         <= lane_out[1];
            out_item_reg.vel_z         <= lane_out[2];
            out_item_reg.rate_x        <= lane_out[3];
            out_item_reg.rate_y        <= lane_out[4];
            out_item_reg.rate_z        <= lane_out[5];
            out_item_reg.target_source <= src_reg;
        end
    end

    assign lane_tgt[0] = item_reg.target_vx;
    assign lane_tgt[1] = item_reg.target_vy;
    assign lane_tgt[2] = item_reg.target_vz;
    assign lane_tgt[3] = item_reg.target_wx;
    assign lane_tgt[4] = item_reg.target_wy;
    assign lane_tgt[5] = item_reg.target_wz;

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        vcs_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .target_in   (lane_tgt[g]),
            .speed_limit ((g < LIN_AXES) ? lin_speed_reg : ang_speed_reg),
            .dt          (dt_reg),
            .den         (den_reg),
            .step_limit  ((g < LIN_AXES) ? md_lin_reg : md_ang_reg),
            .deadband    (db_reg),
            .done        (lane_done[g]),
            .shaped      (lane_out[g])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire
